// ===== src/ufpc_pkg.sv =====
// ----------------------------------------------------------------------------
// ufpc_pkg
// Shared widths, defaults and beat types of the union-find core.
// ----------------------------------------------------------------------------
package ufpc_pkg;

  localparam int ELEMENT_W        = 10;
  localparam int COUNT_W          = 11;
  localparam int MAX_ELEMENTS_DEF = 1024;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);

  localparam logic REQ_UNITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [ELEMENT_W-1:0] element_a;
    logic [ELEMENT_W-1:0] element_b;
  } req_t;

  typedef struct packed {
    logic [ELEMENT_W-1:0] root_a;
    logic [ELEMENT_W-1:0] root_b;
    logic                 same_set;
    logic [COUNT_W-1:0]   set_size_a;
    logic                 index_error;
  } rsp_t;

endpackage

// ===== src/union_find_path_compression_core.sv =====
// ----------------------------------------------------------------------------
// union_find_path_compression_core
// Disjoint-set table, union by size with path compression on every find.
// Steps: find and compress for element_a, then for element_b, then ST_MERGE;
//   a real merge adds ST_LINK. An index error is answered straight from idle.
// One request at a time: the table takes one read and one write per cycle.
// Reset: a clearing pass over all MAX_ELEMENTS entries sets each to -1,
//   busy stays high meanwhile. The result beat cannot be stalled.
// ----------------------------------------------------------------------------
module union_find_path_compression_core #(
  parameter int MAX_ELEMENTS = ufpc_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [ufpc_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                         start,
  input  ufpc_pkg::req_t               req,
  output logic                         busy,
  output logic                         result_valid,
  output ufpc_pkg::rsp_t               result
);

  localparam int IDX_W   = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SIZE_W  = IDX_W + 1;
  localparam int ENTRY_W = IDX_W + 2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FIND  = 3'd2;
  localparam logic [2:0] ST_COMP  = 3'd3;
  localparam logic [2:0] ST_MERGE = 3'd4;
  localparam logic [2:0] ST_LINK  = 3'd5;

  logic [ENTRY_W-1:0] po_mem [MAX_ELEMENTS];
  logic [ENTRY_W-1:0] rd_data;

  logic [ufpc_pkg::COUNT_W-1:0] element_count;
  logic [2:0]        state;
  logic              phase;
  logic              op_type;
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  start_node;
  logic [IDX_W-1:0]  elem_b;
  logic [IDX_W-1:0]  walk_root;
  logic [SIZE_W-1:0] walk_size;
  logic [IDX_W-1:0]  ra;
  logic [IDX_W-1:0]  rb;
  logic [SIZE_W-1:0] size_a;
  logic [SIZE_W-1:0] size_b;
  logic [IDX_W-1:0]  big_root;
  logic [IDX_W-1:0]  small_root;
  logic [SIZE_W-1:0] merged_size;

  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]   mem_raddr;

  logic               rd_neg;
  logic [IDX_W-1:0]   rd_idx;
  logic [ENTRY_W-1:0] rd_negated;
  logic [SIZE_W-1:0]  rd_size;
  logic               req_oob;
  logic [SIZE_W-1:0]  sum_size;
  logic [ENTRY_W-1:0] neg_sum;
  logic               a_smaller;

  assign busy = (state != ST_IDLE);

  assign rd_neg     = rd_data[ENTRY_W-1];
  assign rd_idx     = rd_data[IDX_W-1:0];
  assign rd_negated = '0 - rd_data;
  assign rd_size    = rd_negated[SIZE_W-1:0];
  assign sum_size   = size_a + size_b;
  assign neg_sum    = '0 - ENTRY_W'(sum_size);
  assign a_smaller  = (size_a < size_b);

  assign req_oob = (ufpc_pkg::COUNT_W'(req.element_a) >= element_count) ||
                   (ufpc_pkg::COUNT_W'(req.element_b) >= element_count) ||
                   (32'(req.element_a) >= MAX_ELEMENTS) ||
                   (32'(req.element_b) >= MAX_ELEMENTS);

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = '1;
    mem_raddr = cur;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_raddr = IDX_W'(req.element_a);
      end
      ST_FIND: begin
        mem_raddr = rd_neg ? start_node : rd_idx;
      end
      ST_COMP: begin
        if (cur == walk_root) begin
          mem_raddr = elem_b;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = ENTRY_W'(walk_root);
          mem_raddr = rd_idx;
        end
      end
      ST_MERGE: begin
        mem_we    = (op_type == ufpc_pkg::REQ_UNITE) && (ra != rb);
        mem_waddr = a_smaller ? rb : ra;
        mem_wdata = neg_sum;
      end
      ST_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = small_root;
        mem_wdata = ENTRY_W'(big_root);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      po_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= po_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= ufpc_pkg::COUNT_RESET;
    end else if (cfg_wr_en) begin
      element_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      cur          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          cur <= cur + IDX_W'(1);
          if (cur == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            if (req_oob) begin
              result.root_a      <= '0;
              result.root_b      <= '0;
              result.same_set    <= 1'b0;
              result.set_size_a  <= '0;
              result.index_error <= 1'b1;
              result_valid       <= 1'b1;
            end else begin
              op_type    <= req.req_type;
              elem_b     <= IDX_W'(req.element_b);
              cur        <= IDX_W'(req.element_a);
              start_node <= IDX_W'(req.element_a);
              phase      <= 1'b0;
              state      <= ST_FIND;
            end
          end
        end
        ST_FIND: begin
          if (rd_neg) begin
            walk_root <= cur;
            walk_size <= rd_size;
            cur       <= start_node;
            state     <= ST_COMP;
          end else begin
            cur <= rd_idx;
          end
        end
        ST_COMP: begin
          if (cur == walk_root) begin
            if (!phase) begin
              ra         <= walk_root;
              size_a     <= walk_size;
              phase      <= 1'b1;
              cur        <= elem_b;
              start_node <= elem_b;
              state      <= ST_FIND;
            end else begin
              rb     <= walk_root;
              size_b <= walk_size;
              state  <= ST_MERGE;
            end
          end else begin
            cur <= rd_idx;
          end
        end
        ST_MERGE: begin
          if ((op_type == ufpc_pkg::REQ_UNITE) && (ra != rb)) begin
            big_root    <= a_smaller ? rb : ra;
            small_root  <= a_smaller ? ra : rb;
            merged_size <= sum_size;
            state       <= ST_LINK;
          end else begin
            result.root_a      <= ufpc_pkg::ELEMENT_W'(ra);
            result.root_b      <= ufpc_pkg::ELEMENT_W'(rb);
            result.same_set    <= (ra == rb);
            result.set_size_a  <= ufpc_pkg::COUNT_W'(size_a);
            result.index_error <= 1'b0;
            result_valid       <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        ST_LINK: begin
          result.root_a      <= ufpc_pkg::ELEMENT_W'(big_root);
          result.root_b      <= ufpc_pkg::ELEMENT_W'(rb);
          result.same_set    <= 1'b0;
          result.set_size_a  <= ufpc_pkg::COUNT_W'(merged_size);
          result.index_error <= 1'b0;
          result_valid       <= 1'b1;
          state              <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
